// ===== rtl/est_pkg.sv =====
// Package for the expiring subscription table.
// Holds sizes, op codes, item and result structs, controller command and status.
// No dependencies.
package est_pkg;

    localparam int ENTRIES       = 8;
    localparam int PAYLOAD_BYTES = 64;
    localparam int ENTRY_W       = $clog2(ENTRIES);
    localparam int PL_W          = $clog2(PAYLOAD_BYTES);
    localparam int CNT_W         = 7;
    localparam int RAM_DEPTH     = ENTRIES * PAYLOAD_BYTES;
    localparam int RAM_AW        = ENTRY_W + PL_W;
    localparam logic [31:0] LEASE_RESET = 32'd10000;

    typedef enum logic [1:0] {
        OP_QUERY     = 2'd0,
        OP_SUBSCRIBE = 2'd1,
        OP_TRANSFER  = 2'd2,
        OP_READ      = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] type_id;
        logic [63:0] type_signature;
        logic [31:0] now_ms;
        logic        is_broadcast;
        logic [15:0] transfer_len;
        logic [5:0]  byte_index;
        logic [7:0]  in_byte;
    } t_item;

    typedef struct packed {
        logic        hit;
        logic [63:0] out_signature;
        logic [31:0] age_ms;
        logic [6:0]  stored_len;
        logic [7:0]  out_byte;
        logic        last;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic claim;
        logic clr_step;
        logic single;
        logic rd_start;
        logic rd_emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
        logic claim_needed;
        logic read_stream;
        logic clr_last;
        logic rd_last;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/est_if.sv =====
// Handshake channel interfaces: request item, result item, lease config write.
// Depends on est_pkg.
interface est_in_if;
    import est_pkg::*;
    logic  valid;
    logic  ready;
    t_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface est_out_if;
    import est_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface est_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/est_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module est_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/est_ctrl.sv =====
// Controller state machine: sequences load, table scan, execute, row clear, read stream.
// Depends on est_pkg.
module est_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  est_pkg::t_status i_st,
    output est_pkg::t_cmd    o_cmd
);
    import est_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_EXEC, S_CLEAR, S_RD_ADDR, S_RD_OUT
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_st.scan_last) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                priority if (i_st.claim_needed) begin
                    o_cmd.claim = 1'b1;
                    n_state     = S_CLEAR;
                end else if (i_st.read_stream) begin
                    o_cmd.rd_start = 1'b1;
                    n_state        = S_RD_ADDR;
                end else if (i_st.out_free) begin
                    o_cmd.single = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_st.clr_last) begin
                    n_state = S_EXEC;
                end
            end
            S_RD_ADDR: begin
                n_state = S_RD_OUT;
            end
            S_RD_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.rd_emit = 1'b1;
                    n_state       = i_st.rd_last ? S_IDLE : S_RD_ADDR;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== rtl/est_dp.sv =====
// Datapath: entry table, scan unit, payload RAM, output register, lease register.
// Depends on est_pkg, est_if, est_ram.
module est_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  est_pkg::t_item   i_item,
    input  est_pkg::t_cmd    i_cmd,
    output est_pkg::t_status o_st,
    est_out_if.source        o_out,
    est_cfg_if.sink          i_cfg
);
    import est_pkg::*;

    logic [31:0]        r_lease_ms;
    logic [15:0]        r_tid      [ENTRIES];
    logic [63:0]        r_sig      [ENTRIES];
    logic [31:0]        r_lease_end[ENTRIES];
    logic [31:0]        r_upd      [ENTRIES];
    logic [CNT_W-1:0]   r_cnt      [ENTRIES];

    t_item              r_item;
    logic [ENTRY_W-1:0] r_idx;
    logic               r_match_found;
    logic [ENTRY_W-1:0] r_match_idx;
    logic               r_free_found;
    logic [ENTRY_W-1:0] r_free_idx;
    logic [CNT_W-1:0]   r_k;
    logic               r_out_valid;
    t_result            r_out_data;

    logic               w_live;
    logic [ENTRY_W-1:0] w_m;
    logic [CNT_W-1:0]   w_tcnt;
    logic               w_sub_upd;
    logic               w_xfer_upd;
    logic [31:0]        w_age;
    t_result            w_single_res;
    t_result            w_rd_res;
    logic               w_we;
    logic [RAM_AW-1:0]  w_waddr;
    logic [7:0]         w_wdata;
    logic [7:0]         w_rdata;

    assign w_m    = r_match_idx;
    assign w_live = r_lease_end[r_idx] > r_item.now_ms;
    assign w_age  = r_item.now_ms - r_upd[w_m];
    assign w_tcnt = (r_item.transfer_len > 16'(PAYLOAD_BYTES)) ? CNT_W'(PAYLOAD_BYTES)
                                                                : r_item.transfer_len[CNT_W-1:0];

    // status to the controller
    assign o_st.scan_last    = (r_idx == ENTRY_W'(ENTRIES - 1));
    assign o_st.claim_needed = (r_item.op == OP_SUBSCRIBE) && (r_item.type_signature != '0)
                               && !r_match_found && r_free_found;
    assign o_st.read_stream  = (r_item.op == OP_READ) && r_match_found
                               && (r_upd[w_m] != '0) && (r_cnt[w_m] != '0);
    assign o_st.clr_last     = (r_k[PL_W-1:0] == PL_W'(PAYLOAD_BYTES - 1));
    assign o_st.rd_last      = ((r_k + CNT_W'(1)) == r_cnt[w_m]);
    assign o_st.out_free     = !r_out_valid || o_out.ready;

    // single-result ops and their table updates
    always_comb begin
        w_single_res      = '0;
        w_single_res.last = 1'b1;
        w_sub_upd         = 1'b0;
        w_xfer_upd        = 1'b0;
        unique case (r_item.op)
            OP_QUERY: begin
                if (r_match_found) begin
                    w_single_res.hit           = 1'b1;
                    w_single_res.out_signature = r_sig[w_m];
                end
            end
            OP_SUBSCRIBE: begin
                if (r_item.type_signature != '0 && r_match_found) begin
                    w_sub_upd                  = 1'b1;
                    w_single_res.hit           = 1'b1;
                    w_single_res.out_signature = r_item.type_signature;
                end
            end
            OP_TRANSFER: begin
                if (r_item.is_broadcast && r_match_found) begin
                    w_xfer_upd              = 1'b1;
                    w_single_res.hit        = 1'b1;
                    w_single_res.stored_len = w_tcnt;
                end
            end
            OP_READ: begin
                // updated entry with no bytes stored
                if (r_match_found && r_upd[w_m] != '0) begin
                    w_single_res.hit           = 1'b1;
                    w_single_res.out_signature = r_sig[w_m];
                    w_single_res.age_ms        = w_age;
                end
            end
            default: begin
                w_single_res.hit = 1'b0;
            end
        endcase
    end

    // one streamed payload byte
    always_comb begin
        w_rd_res.hit           = 1'b1;
        w_rd_res.out_signature = r_sig[w_m];
        w_rd_res.age_ms        = w_age;
        w_rd_res.stored_len    = r_cnt[w_m];
        w_rd_res.out_byte      = w_rdata;
        w_rd_res.last          = o_st.rd_last;
    end

    // payload RAM port muxing: row clear or byte store
    assign w_we    = i_cmd.clr_step || (i_cmd.single && w_xfer_upd
                     && ({1'b0, r_item.byte_index} < w_tcnt));
    assign w_waddr = i_cmd.clr_step ? {w_m, r_k[PL_W-1:0]} : {w_m, r_item.byte_index};
    assign w_wdata = i_cmd.clr_step ? 8'd0 : r_item.in_byte;

    est_ram #(
        .WIDTH(8),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr({w_m, r_k[PL_W-1:0]}),
        .o_rdata(w_rdata)
    );

    // control state and entry table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lease_ms    <= LEASE_RESET;
            r_idx         <= '0;
            r_match_found <= 1'b0;
            r_match_idx   <= '0;
            r_free_found  <= 1'b0;
            r_free_idx    <= '0;
            r_k           <= '0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_tid[i]       <= '0;
                r_sig[i]       <= '0;
                r_lease_end[i] <= '0;
                r_upd[i]       <= '0;
                r_cnt[i]       <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_lease_ms <= i_cfg.data;
            end
            // output register: load wins over drain
            if (i_cmd.single || i_cmd.rd_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load) begin
                r_idx         <= '0;
                r_match_found <= 1'b0;
                r_free_found  <= 1'b0;
            end
            // one entry per cycle: first live match, first expired slot
            if (i_cmd.scan) begin
                r_idx <= r_idx + ENTRY_W'(1);
                if (w_live && r_tid[r_idx] == r_item.type_id && !r_match_found) begin
                    r_match_found <= 1'b1;
                    r_match_idx   <= r_idx;
                end
                if (!w_live && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_idx;
                end
            end
            if (i_cmd.claim) begin
                r_tid[r_free_idx] <= r_item.type_id;
                r_upd[r_free_idx] <= '0;
                r_cnt[r_free_idx] <= '0;
                r_match_found     <= 1'b1;
                r_match_idx       <= r_free_idx;
                r_k               <= '0;
            end
            if (i_cmd.clr_step) begin
                r_k <= r_k + CNT_W'(1);
            end
            if (i_cmd.single) begin
                if (w_sub_upd) begin
                    r_sig[w_m]       <= r_item.type_signature;
                    r_lease_end[w_m] <= r_item.now_ms + r_lease_ms;
                end
                if (w_xfer_upd) begin
                    r_cnt[w_m] <= w_tcnt;
                    r_upd[w_m] <= r_item.now_ms;
                end
            end
            if (i_cmd.rd_start) begin
                r_k <= '0;
            end
            if (i_cmd.rd_emit) begin
                r_k <= r_k + CNT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.single) begin
            r_out_data <= w_single_res;
        end else if (i_cmd.rd_emit) begin
            r_out_data <= w_rd_res;
        end
    end

    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // a pending result is never overwritten
    a_single_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.single |-> (!r_out_valid || o_out.ready))
        else $error("single result loaded over pending result");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_emit |-> (!r_out_valid || o_out.ready))
        else $error("read byte loaded over pending result");
    // a slot is claimed only when no live match exists and a free slot was found
    a_claim_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.claim |-> (r_free_found && !r_match_found))
        else $error("claim without free slot");
    // a read stream starts at byte zero of a live, matched entry
    a_rd_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_start |=> (r_k == '0 && r_match_found))
        else $error("read stream not started at byte zero");
endmodule

// ===== rtl/expiring_subscription_table.sv =====
// Top level of the expiring subscription table.
// Depends on est_pkg, est_if, est_ctrl, est_dp (and est_ram below it).
//
//   channel  dir  carries                                  accepted when
//   i_in     in   op, type id, signature, time, byte info  valid && ready
//   o_out    out  hit, signature, age, length, byte, last  valid && ready
//   i_cfg    in   lease_ms write data                      valid && ready
//
// Query, subscribe and transfer pass through load, scan and execute; the scan checks the 8
// table entries, one table entry per cycle (16-bit type id compare, 32-bit lease compare).
// A subscribe that claims an expired slot adds a claim step and a clear of its 64-byte row.
// A read that hits stored bytes streams them from the payload RAM read port, byte by byte.
// Reset clears the table metadata at once; payload rows are zeroed on claim.
// A stalled output holds the result; the next request is taken while it waits.
module expiring_subscription_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    est_in_if.sink    i_in,
    est_out_if.source o_out,
    est_cfg_if.sink   i_cfg
);
    import est_pkg::*;

    t_cmd    w_cmd;
    t_status w_st;
    logic    w_in_ready;

    assign i_in.ready = w_in_ready;

    est_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(w_in_ready),
        .i_st      (w_st),
        .o_cmd     (w_cmd)
    );

    est_dp u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (i_in.data),
        .i_cmd  (w_cmd),
        .o_st   (w_st),
        .o_out  (o_out),
        .i_cfg  (i_cfg)
    );
endmodule
